[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the synchronous reset is low
`define FASR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the usual clock and reset names
`define FASR_ASSERT(lbl, prop, msg) `FASR_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

[sv/fasr_pkg.sv]
// shared widths and operation codes of the fraction add/sub block
`timescale 1ns / 1ps
`default_nettype none

package fasr_pkg;

    // result field widths
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    // operations of the shared adder
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

`default_nettype wire

[sv/fasr_alu.sv]
// shared add/subtract unit used by the multiply, add, subtract, gcd and divide steps of the sequencer
`timescale 1ns / 1ps
`default_nettype none

module fasr_alu #(
    parameter int WIDTH = 34
) (
    input  fasr_pkg::t_alu_op   i_op,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    output logic [WIDTH-1:0]    o_res
);
    import fasr_pkg::*;

    // one wide adder, b inverted for subtract
    always_comb begin
        case (i_op)
            ALU_SUB: o_res = i_a - i_b;
            default: o_res = i_a + i_b;
        endcase
    end

endmodule

`default_nettype wire

[sv/fraction_add_sub_reduce.sv]
// top level: sum and difference of two fractions, reduced by their gcd
//
// Usage: drive the four IN_WIDTH-bit two's complement fields and raise start.
// A beat is taken at a rising edge with start high and busy low. busy then
// stays high until the result beat, which sits on the o_ result ports for
// exactly one cycle marked by o_valid; the receiver cannot stall it, so
// capture it in that cycle. The sum fields may change once the next item runs.
// A zero denominator gives o_valid in the cycle after the beat with
// o_zero_den_error set and all four result fields zero; busy stays low.
// Otherwise one shared add/subtract unit does all the work in turn:
//   three shift-add products
//   sum and difference
//   per result (sum, then diff)   a setup step, binary gcd (one subtract,
//                                 swap or shift a cycle), two restoring
//                                 divisions (numerator, then denominator)
// A zero numerator skips its gcd and divisions (denominator 1).
// The wait for the result beat varies with the gcd loops; the next beat can
// be taken while o_valid is high.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; an item in flight is abandoned.
`timescale 1ns / 1ps
`default_nettype none

module fraction_add_sub_reduce #(
    parameter int IN_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [IN_WIDTH-1:0]        i_num_first,
    input  logic signed [IN_WIDTH-1:0]        i_den_first,
    input  logic signed [IN_WIDTH-1:0]        i_num_second,
    input  logic signed [IN_WIDTH-1:0]        i_den_second,
    output logic                              o_valid,
    output logic signed [fasr_pkg::NUM_W-1:0] o_sum_num,
    output logic        [fasr_pkg::DEN_W-1:0] o_sum_den,
    output logic signed [fasr_pkg::NUM_W-1:0] o_diff_num,
    output logic        [fasr_pkg::DEN_W-1:0] o_diff_den,
    output logic                              o_zero_den_error
);
    import fasr_pkg::*;

    localparam int MW  = 2 * IN_WIDTH;
    localparam int AW  = MW + 2;
    localparam int CW  = $clog2(MW);
    localparam int EXT = (MW > NUM_W) ? MW : NUM_W;

    localparam logic [CW-1:0] CNT_MUL_END = CW'(IN_WIDTH - 1);
    localparam logic [CW-1:0] CNT_DIV_END = CW'(MW - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIFF1,
        S_DIFF2,
        S_RED,
        S_GCD,
        S_DIV_N,
        S_DIV_D
    } t_state;

    typedef enum logic [1:0] {
        M_T1,
        M_T2,
        M_DEN
    } t_mul_sel;

    // magnitude of a two's complement value, most negative value included
    function automatic logic [IN_WIDTH-1:0] mag(input logic [IN_WIDTH-1:0] v);
        mag = v[IN_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    t_state                r_state;
    t_mul_sel              r_mul_sel;
    logic [CW-1:0]         r_cnt;
    logic                  r_pass;
    logic                  r_sa, r_sb, r_sc, r_sd;
    logic [IN_WIDTH-1:0]   r_mb, r_mc, r_md;
    logic [IN_WIDTH-1:0]   r_mplier;
    logic [MW-1:0]         r_t1, r_t2, r_den;
    logic [MW-1:0]         r_addm, r_subm;
    logic                  r_subs;
    logic                  r_neg;
    logic [MW-1:0]         r_x, r_y, r_rn, r_rd, r_rem;

    t_alu_op               alu_op;
    logic [AW-1:0]         alu_a, alu_b, alu_res;
    logic                  w_borrow;
    logic                  w_accept;
    logic                  w_den_zero;
    logic                  w_done;
    logic                  w_st1, w_st2, w_dsign, w_use_add, w_nsign;
    logic [MW-1:0]         w_nmag;
    logic [MW-1:0]         w_mul_acc;
    logic [MW:0]           w_rem_sh;
    logic                  w_qbit;
    logic [MW-1:0]         w_rem_next;
    logic [MW-1:0]         w_q_den;
    logic [EXT-1:0]        w_num_ext, w_den_ext;
    logic [NUM_W-1:0]      w_num_mag;
    logic [NUM_W-1:0]      w_num_out;
    logic [DEN_W-1:0]      w_den_out;

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_den_zero = (i_den_first == '0) || (i_den_second == '0);

    // product and result signs
    assign w_st1     = r_sa ^ r_sd;
    assign w_st2     = r_sc ^ r_sb;
    assign w_dsign   = r_sb ^ r_sd;
    assign w_use_add = (w_st1 ~^ w_st2) ^ r_pass;
    assign w_nmag    = w_use_add ? r_addm : r_subm;
    assign w_nsign   = w_use_add ? w_st1 : r_subs;

    // result beat strobe
    assign w_done = (w_accept && w_den_zero)
                 || ((r_state == S_RED) && r_pass && (w_nmag == '0))
                 || ((r_state == S_DIV_D) && r_pass && (r_cnt == CNT_DIV_END));

    // shared unit operand select
    always_comb begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (r_state)
            S_MUL: begin
                alu_a = AW'(r_x);
                alu_b = AW'(r_y);
            end
            S_ADD: begin
                alu_a = AW'(r_t1);
                alu_b = AW'(r_t2);
            end
            S_DIFF1: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(r_t1);
                alu_b  = AW'(r_t2);
            end
            S_DIFF2: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(r_t2);
                alu_b  = AW'(r_t1);
            end
            S_GCD: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(r_x);
                alu_b  = AW'(r_y);
            end
            S_DIV_N, S_DIV_D: begin
                alu_op = ALU_SUB;
                alu_a  = AW'(w_rem_sh);
                alu_b  = AW'(r_x);
            end
            default: begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    fasr_alu #(
        .WIDTH(AW)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign w_borrow = alu_res[AW-1];

    // multiply and divide step values
    assign w_mul_acc  = r_mplier[0] ? alu_res[MW-1:0] : r_x;
    assign w_rem_sh   = {r_rem, ((r_state == S_DIV_N) ? r_rn[MW-1] : r_rd[MW-1])};
    assign w_qbit     = !w_borrow;
    assign w_rem_next = w_qbit ? alu_res[MW-1:0] : w_rem_sh[MW-1:0];

    // final quotients, extended or truncated to the result fields, sign on the numerator
    assign w_q_den   = {r_rd[MW-2:0], w_qbit};
    assign w_num_ext = EXT'(r_rn);
    assign w_den_ext = EXT'(w_q_den);
    assign w_num_mag = w_num_ext[NUM_W-1:0];
    assign w_num_out = r_neg ? (~w_num_mag + 1'b1) : w_num_mag;
    assign w_den_out = w_den_ext[DEN_W-1:0];

    // sequencer, datapath registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_done;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_sa      <= i_num_first[IN_WIDTH-1];
                        r_sb      <= i_den_first[IN_WIDTH-1];
                        r_sc      <= i_num_second[IN_WIDTH-1];
                        r_sd      <= i_den_second[IN_WIDTH-1];
                        r_mb      <= mag(i_den_first);
                        r_mc      <= mag(i_num_second);
                        r_md      <= mag(i_den_second);
                        r_x       <= '0;
                        r_y       <= MW'(mag(i_num_first));
                        r_mplier  <= mag(i_den_second);
                        r_cnt     <= '0;
                        r_mul_sel <= M_T1;
                        r_pass    <= 1'b0;
                        if (w_den_zero) begin
                            o_sum_num        <= '0;
                            o_sum_den        <= '0;
                            o_diff_num       <= '0;
                            o_diff_den       <= '0;
                            o_zero_den_error <= 1'b1;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                // shift-add multiply, one multiplier bit a cycle
                S_MUL: begin
                    if (r_cnt == CNT_MUL_END) begin
                        r_cnt <= '0;
                        r_x   <= '0;
                        case (r_mul_sel)
                            M_T1: begin
                                r_t1      <= w_mul_acc;
                                r_y       <= MW'(r_mc);
                                r_mplier  <= r_mb;
                                r_mul_sel <= M_T2;
                            end
                            M_T2: begin
                                r_t2      <= w_mul_acc;
                                r_y       <= MW'(r_mb);
                                r_mplier  <= r_md;
                                r_mul_sel <= M_DEN;
                            end
                            default: begin
                                r_den   <= w_mul_acc;
                                r_state <= S_ADD;
                            end
                        endcase
                    end else begin
                        r_x      <= w_mul_acc;
                        r_y      <= r_y << 1;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt + 1'b1;
                    end
                end
                // magnitude sum of the two cross products
                S_ADD: begin
                    r_addm  <= alu_res[MW-1:0];
                    r_state <= S_DIFF1;
                end
                // magnitude difference, larger minus smaller
                S_DIFF1: begin
                    if (!w_borrow) begin
                        r_subm  <= alu_res[MW-1:0];
                        r_subs  <= w_st1;
                        r_state <= S_RED;
                    end else begin
                        r_state <= S_DIFF2;
                    end
                end
                S_DIFF2: begin
                    r_subm  <= alu_res[MW-1:0];
                    r_subs  <= !w_st1;
                    r_state <= S_RED;
                end
                // set up one reduction, zero numerator is done at once
                S_RED: begin
                    r_neg <= w_nsign ^ w_dsign;
                    if (w_nmag == '0) begin
                        if (r_pass) begin
                            o_diff_num       <= '0;
                            o_diff_den       <= DEN_W'(1);
                            o_zero_den_error <= 1'b0;
                            r_state          <= S_IDLE;
                        end else begin
                            o_sum_num <= '0;
                            o_sum_den <= DEN_W'(1);
                            r_pass    <= 1'b1;
                        end
                    end else begin
                        r_x     <= w_nmag;
                        r_y     <= r_den;
                        r_rn    <= w_nmag;
                        r_rd    <= r_den;
                        r_state <= S_GCD;
                    end
                end
                // binary gcd; common twos are divided out of the operands too
                S_GCD: begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x  <= r_x >> 1;
                        r_y  <= r_y >> 1;
                        r_rn <= r_rn >> 1;
                        r_rd <= r_rd >> 1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (alu_res == '0) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV_N;
                    end else if (w_borrow) begin
                        r_x <= r_y;
                        r_y <= r_x;
                    end else begin
                        r_x <= alu_res[MW-1:0];
                    end
                end
                // restoring division of the numerator by the gcd
                S_DIV_N: begin
                    r_rn <= {r_rn[MW-2:0], w_qbit};
                    if (r_cnt == CNT_DIV_END) begin
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV_D;
                    end else begin
                        r_rem <= w_rem_next;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                // restoring division of the denominator, then write the result
                S_DIV_D: begin
                    r_rd <= w_q_den;
                    if (r_cnt == CNT_DIV_END) begin
                        r_cnt <= '0;
                        if (r_pass) begin
                            o_diff_num       <= w_num_out;
                            o_diff_den       <= w_den_out;
                            o_zero_den_error <= 1'b0;
                            r_state          <= S_IDLE;
                        end else begin
                            o_sum_num <= w_num_out;
                            o_sum_den <= w_den_out;
                            r_pass    <= 1'b1;
                            r_state   <= S_RED;
                        end
                    end else begin
                        r_rem <= w_rem_next;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/fasr_checker.sv]
// port-level checker for the fraction add/sub block and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fasr_checker #(
    parameter int IN_WIDTH = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [IN_WIDTH-1:0]               i_den_first,
    input logic [IN_WIDTH-1:0]               i_den_second,
    input logic                              o_valid,
    input logic [fasr_pkg::NUM_W-1:0]        o_sum_num,
    input logic [fasr_pkg::DEN_W-1:0]        o_sum_den,
    input logic [fasr_pkg::NUM_W-1:0]        o_diff_num,
    input logic [fasr_pkg::DEN_W-1:0]        o_diff_den,
    input logic                              o_zero_den_error
);
    import fasr_pkg::*;

    // busy only goes high after an accepted beat
    `FASR_ASSERT(a_busy_rise, $rose(busy) |-> $past(start), "busy rose without a start beat")

    // the sequencer only leaves work through a result beat
    `FASR_ASSERT(a_busy_fall, $fell(busy) && $past(i_rst_n) |-> o_valid, "busy fell without a result beat")

    // zero denominator answers in the next cycle with the error flag
    `FASR_ASSERT(a_zero_den, start && !busy && (i_den_first == '0 || i_den_second == '0) |=> o_valid && o_zero_den_error, "zero denominator not flagged")

    // an error beat carries all-zero result fields
    `FASR_ASSERT(a_err_zero, o_valid && o_zero_den_error |-> o_sum_num == '0 && o_sum_den == '0 && o_diff_num == '0 && o_diff_den == '0, "error beat with nonzero fields")

endmodule

bind fraction_add_sub_reduce fasr_checker #(
    .IN_WIDTH(IN_WIDTH)
) u_fasr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_den_first      (i_den_first),
    .i_den_second     (i_den_second),
    .o_valid          (o_valid),
    .o_sum_num        (o_sum_num),
    .o_sum_den        (o_sum_den),
    .o_diff_num       (o_diff_num),
    .o_diff_den       (o_diff_den),
    .o_zero_den_error (o_zero_den_error)
);

`default_nettype wire
